// File: rtl/rbs_pkg.sv
// shared types, codes and constants of the reconnect backoff scheduler
package rbs_pkg;

  localparam int DEFAULT_ENTRIES = 8;

  localparam int ADDR_W = 48;
  localparam int TIME_W = 32;
  localparam int CNT8_W = 8;
  localparam int ST_W   = 3;
  localparam int CMD_W  = 3;

  // commands
  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENABLE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DISABLE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CONNECTED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FAILED    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LOST      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SET_PRIO  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd7;

  // peer states
  localparam logic [ST_W-1:0] ST_IDLE       = 3'd0;
  localparam logic [ST_W-1:0] ST_SEARCHING  = 3'd1;
  localparam logic [ST_W-1:0] ST_CONNECTING = 3'd2;
  localparam logic [ST_W-1:0] ST_CONNECTED  = 3'd3;
  localparam logic [ST_W-1:0] ST_BACKOFF    = 3'd4;
  localparam logic [ST_W-1:0] ST_FAILED     = 3'd5;
  localparam logic [ST_W-1:0] ST_DISABLED   = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_RETRY_INTERVAL = 2'd0;
  localparam logic [1:0] REG_BACKOFF_CAP    = 2'd1;
  localparam logic [1:0] REG_ATTEMPT_TMO    = 2'd2;

  localparam logic [TIME_W-1:0] RETRY_INTERVAL_RST = 32'd1000;
  localparam logic [TIME_W-1:0] BACKOFF_CAP_RST    = 32'd30000;
  localparam logic [TIME_W-1:0] ATTEMPT_TMO_RST    = 32'd5000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              enabled;
    logic [ST_W-1:0]   status;
    logic [CNT8_W-1:0] retries;
    logic [CNT8_W-1:0] limit;
    logic [TIME_W-1:0] last;
    logic [CNT8_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] base_delay;
    logic [TIME_W-1:0] backoff_cap;
    logic [TIME_W-1:0] attempt_tmo;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              match;
    logic [CNT8_W-1:0] limit;
    logic [CNT8_W-1:0] prio;
    logic [TIME_W-1:0] now;
  } upd_ctrl_t;

endpackage

// File: rtl/rbs_entry_update.sv
// per-entry read-modify-write logic: command effects and tick advance
module rbs_entry_update (
  input  rbs_pkg::upd_ctrl_t ctl,
  input  rbs_pkg::cfg_t      cfg,
  input  rbs_pkg::entry_t    ent_in,
  output rbs_pkg::entry_t    ent_out
);

  logic [31:0] elapsed;
  logic [31:0] delay;
  logic [63:0] shifted;
  logic [7:0]  ret_inc;
  logic        due;

  assign elapsed = ctl.now - ent_in.last;
  assign ret_inc = (ent_in.retries == 8'hff) ? ent_in.retries : ent_in.retries + 8'd1;
  assign shifted = {32'b0, cfg.base_delay} << ent_in.retries[4:0];

  // capped doubling: min(interval * 2^r, cap) for r >= 1
  always_comb begin
    if (ent_in.retries == 8'd0) begin
      delay = cfg.base_delay;
    end else if (cfg.base_delay == 32'd0) begin
      delay = 32'd0;
    end else if (ent_in.retries[7:5] != 3'd0) begin
      delay = cfg.backoff_cap;
    end else if (shifted > {32'b0, cfg.backoff_cap}) begin
      delay = cfg.backoff_cap;
    end else begin
      delay = shifted[31:0];
    end
  end

  assign due = ent_in.enabled && (ent_in.retries < ent_in.limit) && (elapsed >= delay);

  always_comb begin
    ent_out = ent_in;
    if (ctl.cmd == rbs_pkg::CMD_TICK) begin
      if (ent_in.enabled) begin
        case (ent_in.status)
          rbs_pkg::ST_SEARCHING: begin
            if (due) begin
              ent_out.status = rbs_pkg::ST_CONNECTING;
              ent_out.last   = ctl.now;
            end
          end
          rbs_pkg::ST_CONNECTING: begin
            if (elapsed > cfg.attempt_tmo) begin
              ent_out.retries = ret_inc;
              ent_out.status  = (ret_inc >= ent_in.limit) ? rbs_pkg::ST_FAILED
                                                          : rbs_pkg::ST_BACKOFF;
            end
          end
          rbs_pkg::ST_BACKOFF: begin
            if (due) ent_out.status = rbs_pkg::ST_SEARCHING;
          end
          default: ;
        endcase
      end
    end else if (ctl.match) begin
      unique case (ctl.cmd)
        rbs_pkg::CMD_ENABLE: begin
          ent_out.enabled = 1'b1;
          ent_out.limit   = ctl.limit;
          ent_out.retries = 8'd0;
          ent_out.status  = rbs_pkg::ST_SEARCHING;
          ent_out.last    = ctl.now;
        end
        rbs_pkg::CMD_DISABLE: begin
          ent_out.enabled = 1'b0;
          ent_out.status  = rbs_pkg::ST_DISABLED;
        end
        rbs_pkg::CMD_CONNECTED: begin
          ent_out.status  = rbs_pkg::ST_CONNECTED;
          ent_out.retries = 8'd0;
          ent_out.last    = ctl.now;
        end
        rbs_pkg::CMD_FAILED: begin
          ent_out.retries = ret_inc;
          if (ret_inc >= ent_in.limit) begin
            ent_out.status = rbs_pkg::ST_FAILED;
          end else begin
            ent_out.status = rbs_pkg::ST_BACKOFF;
            ent_out.last   = ctl.now;
          end
        end
        rbs_pkg::CMD_LOST: begin
          if (ent_in.enabled) begin
            ent_out.status  = rbs_pkg::ST_SEARCHING;
            ent_out.retries = 8'd0;
            ent_out.last    = ctl.now;
          end
        end
        rbs_pkg::CMD_SET_PRIO: ent_out.prio = ctl.prio;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/reconnect_backoff_scheduler.sv
// top level: peer profile table with capped exponential backoff reconnect
//
// in_*: one command transaction. in_tuser holds the command code, in_tdata the
//   peer address, retry limit, priority and current time in ms.
// out_*: one result transaction per command: addressed peer status, the
//   highest-priority searching peer and the number of active peers.
// cfg_*: register writes (retry interval, backoff cap, attempt timeout); the user
//   must write them only while no command is in flight. The block does not enforce it.
// A command walks the profile table once through a memory with one read and
//   one write port and registered read data: entry i is read, updated and
//   written back while entry i+1 is read. in_tready returns with the result,
//   so a new command is taken only after the previous result is registered.
// in_tready is high only while the sequencer is idle; a new command may be
//   taken while a result still waits in the output register, but that
//   command's result holds the sequencer until the register is free.
// Reset empties the table (fill count zero), clears the reconnect flag and the
//   output valid, and loads the default register values. No clearing pass.
module reconnect_backoff_scheduler #(
  parameter int TABLE_ENTRIES = rbs_pkg::DEFAULT_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // peer_address[47:0], retry_limit[55:48], priority_value[63:56], now_ms[95:64]
  input  logic [95:0] in_tdata,
  // command[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // peer_found[0], peer_enabled[1], peer_state[4:2], peer_retries[12:5],
  // target_valid[13], target_address[61:14], active_count[65:62],
  // reconnecting[66], table_full[67], zero fill[71:68]
  output logic [71:0] out_tdata,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SWEEP  = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  rbs_pkg::entry_t mem [TABLE_ENTRIES];

  logic [1:0]    state_r, state_nxt;
  rbs_pkg::cfg_t cfg_r;
  logic [2:0]    cmd_r;
  logic [47:0]   addr_r;
  logic [7:0]    limit_r, prio_r;
  logic [31:0]   now_r;
  logic [CW-1:0] count_r, idx_r;
  logic          flag_r;
  logic          proc_v_r;
  logic [AW-1:0] proc_idx_r;
  rbs_pkg::entry_t rd_data_r, upd_ent;

  logic          found_r, fen_r;
  logic [2:0]    fst_r;
  logic [7:0]    fret_r;
  logic          tv_r;
  logic [47:0]   taddr_r;
  logic [7:0]    best_r;
  logic [CW-1:0] active_r;
  logic          any_r;

  logic          out_valid_r;
  logic [71:0]   out_data_r;

  rbs_pkg::upd_ctrl_t ctl;
  logic in_acc, issue, last_proc, match, fin_go, fresh, append, full;
  logic take;
  logic          tv_fin;
  logic [47:0]   taddr_fin;
  logic [CW-1:0] active_fin;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign issue     = (state_r == S_SWEEP) && (idx_r != count_r);
  assign last_proc = proc_v_r && ((CW'(proc_idx_r) + CW'(1)) == count_r);
  assign match     = proc_v_r && (rd_data_r.addr == addr_r);

  assign ctl.cmd   = cmd_r;
  assign ctl.match = match;
  assign ctl.limit = limit_r;
  assign ctl.prio  = prio_r;
  assign ctl.now   = now_r;

  rbs_entry_update u_upd (
    .ctl    (ctl),
    .cfg    (cfg_r),
    .ent_in (rd_data_r),
    .ent_out(upd_ent)
  );

  // a new entry is searching with priority 0, so it wins unless a higher one exists
  assign fin_go = (state_r == S_FINISH) && (!out_valid_r || out_tready);
  assign fresh  = (cmd_r == rbs_pkg::CMD_ENABLE) && !found_r;
  assign append = fresh && (count_r != CW'(TABLE_ENTRIES));
  assign full   = fresh && !append;
  assign take   = upd_ent.enabled && (upd_ent.status == rbs_pkg::ST_SEARCHING) &&
                  (upd_ent.prio >= best_r);

  always_comb begin
    tv_fin     = tv_r;
    taddr_fin  = taddr_r;
    active_fin = active_r;
    if (append) begin
      active_fin = active_r + CW'(1);
      if (best_r == 8'd0) begin
        tv_fin    = 1'b1;
        taddr_fin = addr_r;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = (count_r == '0) ? S_FINISH : S_SWEEP;
      S_SWEEP:  if (last_proc) state_nxt = S_FINISH;
      S_FINISH: if (fin_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // table memory: one read and one write per cycle, read data registered
  always_ff @(posedge clk) begin
    if (issue) rd_data_r <= mem[idx_r[AW-1:0]];
    if (proc_v_r) begin
      mem[proc_idx_r] <= upd_ent;
    end else if (fin_go && append) begin
      mem[count_r[AW-1:0]] <= '{addr: addr_r, enabled: 1'b1,
                                status: rbs_pkg::ST_SEARCHING, retries: 8'd0,
                                limit: limit_r, last: now_r, prio: 8'd0};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    proc_idx_r <= idx_r[AW-1:0];
    if (in_acc) begin
      cmd_r   <= in_tuser;
      addr_r  <= in_tdata[47:0];
      limit_r <= in_tdata[55:48];
      prio_r  <= in_tdata[63:56];
      now_r   <= in_tdata[95:64];
      found_r <= 1'b0;
      fen_r   <= 1'b0;
      fst_r   <= rbs_pkg::ST_IDLE;
      fret_r  <= 8'd0;
      tv_r    <= 1'b0;
      taddr_r <= 48'd0;
      best_r  <= 8'd0;
      active_r <= '0;
      any_r   <= 1'b0;
    end else if (proc_v_r) begin
      if (match) begin
        found_r <= 1'b1;
        fen_r   <= upd_ent.enabled;
        fst_r   <= upd_ent.status;
        fret_r  <= upd_ent.retries;
      end
      if (take) begin
        tv_r    <= 1'b1;
        taddr_r <= upd_ent.addr;
        best_r  <= upd_ent.prio;
      end
      if (upd_ent.enabled && upd_ent.status != rbs_pkg::ST_CONNECTED &&
          upd_ent.status != rbs_pkg::ST_DISABLED) begin
        active_r <= active_r + CW'(1);
      end
      if (upd_ent.enabled && upd_ent.status != rbs_pkg::ST_DISABLED) any_r <= 1'b1;
    end
    if (fin_go) begin
      out_data_r <= {4'b0, full, (append ? 1'b1 : ((cmd_r == rbs_pkg::CMD_TICK) ? any_r : flag_r)),
                     4'(active_fin), taddr_fin, tv_fin,
                     (append ? 8'd0 : fret_r),
                     (append ? rbs_pkg::ST_SEARCHING : fst_r),
                     (append ? 1'b1 : fen_r),
                     (append ? 1'b1 : found_r)};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      flag_r      <= 1'b0;
      proc_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{base_delay: rbs_pkg::RETRY_INTERVAL_RST,
                       backoff_cap: rbs_pkg::BACKOFF_CAP_RST,
                       attempt_tmo: rbs_pkg::ATTEMPT_TMO_RST};
    end else begin
      state_r  <= state_nxt;
      proc_v_r <= issue;
      if (in_acc) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + CW'(1);
      end
      if (fin_go) begin
        if (append) begin
          count_r <= count_r + CW'(1);
          flag_r  <= 1'b1;
        end else if (cmd_r == rbs_pkg::CMD_TICK) begin
          flag_r <= any_r;
        end
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wen) begin
        case (cfg_index)
          rbs_pkg::REG_RETRY_INTERVAL: cfg_r.base_delay  <= cfg_wdata;
          rbs_pkg::REG_BACKOFF_CAP:    cfg_r.backoff_cap <= cfg_wdata;
          rbs_pkg::REG_ATTEMPT_TMO:    cfg_r.attempt_tmo <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/rbs_checker.sv
// port-level checks of the reconnect backoff scheduler and their binding
module rbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // one command at a time in the sequencer
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // no target means a zero target address
  a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[13] |-> out_tdata[61:14] == 48'd0)
    else $error("target address without a searching peer");

  // a rejected enable never reports the peer as present
  a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[67] |-> !out_tdata[0] && out_tdata[4:2] == rbs_pkg::ST_IDLE)
    else $error("table full with peer found");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind reconnect_backoff_scheduler rbs_checker u_rbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
